@@ design/circular_queue_with_readout_defines.svh @@
// assertion macros used by the back part of the queue rtl
`ifndef CIRCULAR_QUEUE_WITH_READOUT_DEFINES_SVH
`define CIRCULAR_QUEUE_WITH_READOUT_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define CQR_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cqr check failed");

// next-cycle implication, sampled on clock, off during reset
`define CQR_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cqr check failed");

`endif

@@ design/cqr_pkg.sv @@
// shared types and codes for the circular queue with readout
package cqr_pkg;

   localparam int WORD_W = 32;

   // request action codes
   localparam logic [1:0] ACT_STATUS  = 2'd0;
   localparam logic [1:0] ACT_ENQUEUE = 2'd1;
   localparam logic [1:0] ACT_DEQUEUE = 2'd2;
   localparam logic [1:0] ACT_READOUT = 2'd3;

   // command queue between front and back
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_AW    = 1;
   localparam int CMDQ_CW    = 2;

   typedef enum logic [1:0] {
      OP_STATUS,
      OP_ENQUEUE,
      OP_DEQUEUE,
      OP_READOUT
   } op_type;

   typedef enum logic [1:0] {
      OUTCOME_DONE,
      OUTCOME_FULL,
      OUTCOME_EMPTY
   } outcome_type;

   typedef struct packed {
      op_type                    op;
      logic signed [WORD_W-1:0]  word;
   } cmd_type;

endpackage

@@ design/cqr_ram.sv @@
// generic single-write, single-read ram with registered read data
module cqr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ design/cqr_cmd_queue.sv @@
// two-entry command queue between the front and back parts
module cqr_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  cqr_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output cqr_pkg::cmd_type pop_cmd
);

   cqr_pkg::cmd_type               slots_ff [cqr_pkg::CMDQ_DEPTH];
   logic [cqr_pkg::CMDQ_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [cqr_pkg::CMDQ_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [cqr_pkg::CMDQ_CW-1:0]    count_ff, count_in;
   logic                           push, pop;

   assign push_ready = (count_ff != cqr_pkg::CMDQ_CW'(cqr_pkg::CMDQ_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slots_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ design/cqr_front.sv @@
// front part: accepts request transactions and classifies them into commands
module cqr_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_action,
   input  logic signed [cqr_pkg::WORD_W-1:0]   req_push_word,
   output logic                                push_valid,
   input  logic                                push_ready,
   output cqr_pkg::cmd_type                    push_cmd
);

   logic             cmd_valid_ff, cmd_valid_in;
   cqr_pkg::cmd_type cmd_ff, cmd_in;
   cqr_pkg::cmd_type decoded;
   logic             accept;

   assign req_stall  = cmd_valid_ff && !push_ready;
   assign accept     = req_valid && !req_stall;
   assign push_valid = cmd_valid_ff;
   assign push_cmd   = cmd_ff;

   always_comb begin
      decoded.word = '0;
      unique case (req_action)
         cqr_pkg::ACT_STATUS:  decoded.op = cqr_pkg::OP_STATUS;
         cqr_pkg::ACT_ENQUEUE: begin
            decoded.op   = cqr_pkg::OP_ENQUEUE;
            decoded.word = req_push_word;
         end
         cqr_pkg::ACT_DEQUEUE: decoded.op = cqr_pkg::OP_DEQUEUE;
         cqr_pkg::ACT_READOUT: decoded.op = cqr_pkg::OP_READOUT;
         default:              decoded.op = cqr_pkg::OP_STATUS;
      endcase
   end

   always_comb begin
      cmd_valid_in = accept || (cmd_valid_ff && !push_ready);
      cmd_in       = accept ? decoded : cmd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

@@ design/cqr_back.sv @@
// back part: ring-buffer state, word store and result register
`include "circular_queue_with_readout_defines.svh"

module cqr_back #(
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                pop_valid,
   output logic                                pop_ready,
   input  cqr_pkg::cmd_type                    pop_cmd,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [cqr_pkg::WORD_W-1:0]   rsp_word_out,
   output logic                                rsp_word_valid,
   output logic [1:0]                          rsp_outcome,
   output logic                                rsp_is_empty,
   output logic                                rsp_is_full,
   output logic                                rsp_last_of_run
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] idx);
      return (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   state_type                        state_ff, state_in;
   logic [AW-1:0]                    head_ff, head_in;
   logic [AW-1:0]                    tail_ff, tail_in;
   logic [CW-1:0]                    count_ff, count_in;
   logic [AW-1:0]                    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]                    remaining_ff, remaining_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic signed [cqr_pkg::WORD_W-1:0] rsp_word_ff, rsp_word_in;
   logic                             rsp_word_valid_ff, rsp_word_valid_in;
   cqr_pkg::outcome_type             rsp_outcome_ff, rsp_outcome_in;
   logic                             rsp_empty_ff, rsp_empty_in;
   logic                             rsp_full_ff, rsp_full_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic                             out_free;
   logic                             load;
   logic                             is_empty_now, is_full_now;
   logic                             ram_we, ram_re;
   logic [AW-1:0]                    ram_raddr;
   logic [cqr_pkg::WORD_W-1:0]       ram_rdata;

   cqr_ram #(
      .WIDTH (cqr_pkg::WORD_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (tail_ff),
      .wdata (pop_cmd.word),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign is_empty_now = (count_ff == '0);
   assign is_full_now  = (count_ff == CW'(DEPTH));

   always_comb begin
      state_in          = state_ff;
      head_in           = head_ff;
      tail_in           = tail_ff;
      count_in          = count_ff;
      rd_ptr_in         = rd_ptr_ff;
      remaining_in      = remaining_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_word_in       = rsp_word_ff;
      rsp_word_valid_in = rsp_word_valid_ff;
      rsp_outcome_in    = rsp_outcome_ff;
      rsp_empty_in      = rsp_empty_ff;
      rsp_full_in       = rsp_full_ff;
      rsp_last_in       = rsp_last_ff;
      pop_ready         = 1'b0;
      load              = 1'b0;
      ram_we            = 1'b0;
      ram_re            = 1'b0;
      ram_raddr         = head_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (pop_valid && out_free) begin
               pop_ready         = 1'b1;
               load              = 1'b1;
               rsp_valid_in      = 1'b1;
               rsp_word_in       = '0;
               rsp_word_valid_in = 1'b0;
               rsp_outcome_in    = cqr_pkg::OUTCOME_DONE;
               rsp_last_in       = 1'b1;
               unique case (pop_cmd.op)
                  cqr_pkg::OP_STATUS: begin
                  end
                  cqr_pkg::OP_ENQUEUE: begin
                     if (is_full_now) begin
                        rsp_outcome_in = cqr_pkg::OUTCOME_FULL;
                     end else begin
                        ram_we   = 1'b1;
                        tail_in  = wrap_next(tail_ff);
                        count_in = count_ff + 1'b1;
                     end
                  end
                  cqr_pkg::OP_DEQUEUE: begin
                     if (is_empty_now) begin
                        rsp_outcome_in = cqr_pkg::OUTCOME_EMPTY;
                     end else begin
                        // word comes back from the store next cycle
                        load         = 1'b0;
                        rsp_valid_in = 1'b0;
                        ram_re       = 1'b1;
                        head_in      = wrap_next(head_ff);
                        count_in     = count_ff - 1'b1;
                        remaining_in = '0;
                        state_in     = S_READ;
                     end
                  end
                  cqr_pkg::OP_READOUT: begin
                     if (is_empty_now) begin
                        rsp_outcome_in = cqr_pkg::OUTCOME_EMPTY;
                     end else begin
                        load         = 1'b0;
                        rsp_valid_in = 1'b0;
                        ram_re       = 1'b1;
                        rd_ptr_in    = wrap_next(head_ff);
                        remaining_in = count_ff - 1'b1;
                        state_in     = S_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            // read data is held by the store until the next read
            if (out_free) begin
               load              = 1'b1;
               rsp_valid_in      = 1'b1;
               rsp_word_in       = $signed(ram_rdata);
               rsp_word_valid_in = 1'b1;
               rsp_outcome_in    = cqr_pkg::OUTCOME_DONE;
               rsp_last_in       = (remaining_ff == '0);
               if (remaining_ff != '0) begin
                  ram_re       = 1'b1;
                  ram_raddr    = rd_ptr_ff;
                  rd_ptr_in    = wrap_next(rd_ptr_ff);
                  remaining_in = remaining_ff - 1'b1;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (load) begin
         rsp_empty_in = (count_in == '0);
         rsp_full_in  = (count_in == CW'(DEPTH));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rd_ptr_ff    <= '0;
         remaining_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rd_ptr_ff    <= rd_ptr_in;
         remaining_ff <= remaining_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff       <= rsp_word_in;
      rsp_word_valid_ff <= rsp_word_valid_in;
      rsp_outcome_ff    <= rsp_outcome_in;
      rsp_empty_ff      <= rsp_empty_in;
      rsp_full_ff       <= rsp_full_in;
      rsp_last_ff       <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_word_out    = rsp_word_ff;
   assign rsp_word_valid  = rsp_word_valid_ff;
   assign rsp_outcome     = rsp_outcome_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_is_full     = rsp_full_ff;
   assign rsp_last_of_run = rsp_last_ff;

   `CQR_ASSERT_IMP(a_count_in_range, 1'b1, count_ff <= CW'(DEPTH))
   `CQR_ASSERT_IMP(a_no_write_when_full, ram_we, !is_full_now)
   `CQR_ASSERT_IMP(a_single_store_access, ram_we, !ram_re)
   `CQR_ASSERT_IMP(a_run_within_count, state_ff == S_READ, remaining_ff <= count_ff)

endmodule

@@ design/circular_queue_with_readout.sv @@
// A ring-buffer queue of DEPTH signed 32-bit words with status, enqueue, dequeue and readout
// requests. A request transaction passes a front register and a two-entry command queue before
// the back part executes it. A stream of status and enqueue requests runs at one per cycle
// unless rsp_stall holds; dequeue goes through S_READ because the word store has a registered
// read port; readout does too and delivers one word per cycle unless rsp_stall holds, oldest
// first, limited by the single read port of the store. Refused requests and readout of an
// empty queue give one result. Every result reports the empty and full state after the step.
module circular_queue_with_readout #(
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_action,
   input  logic signed [cqr_pkg::WORD_W-1:0]   req_push_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [cqr_pkg::WORD_W-1:0]   rsp_word_out,
   output logic                                rsp_word_valid,
   output logic [1:0]                          rsp_outcome,
   output logic                                rsp_is_empty,
   output logic                                rsp_is_full,
   output logic                                rsp_last_of_run
);

   logic             fq_valid, fq_ready;
   cqr_pkg::cmd_type fq_cmd;
   logic             qb_valid, qb_ready;
   cqr_pkg::cmd_type qb_cmd;

   cqr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_push_word (req_push_word),
      .push_valid    (fq_valid),
      .push_ready    (fq_ready),
      .push_cmd      (fq_cmd)
   );

   cqr_cmd_queue u_cmd_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_cmd   (fq_cmd),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_cmd    (qb_cmd)
   );

   cqr_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (qb_valid),
      .pop_ready       (qb_ready),
      .pop_cmd         (qb_cmd),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_word_out    (rsp_word_out),
      .rsp_word_valid  (rsp_word_valid),
      .rsp_outcome     (rsp_outcome),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
